>>> design/cpe_pkg.sv
// shared types, constants and constant tables of the compressed position encoder
package cpe_pkg;

  // field characters
  localparam logic [7:0] CHR_BANG = 8'h21;
  localparam logic [7:0] CHR_TAIL = 8'h47;
  localparam logic [7:0] CHR_OFS  = 8'd33;

  localparam int FRAME_BYTES = 14;
  localparam int CNT_W       = 4;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_OVERLAY = 1'b0;
  localparam logic [0:0] REG_SYMBOL  = 1'b1;
  localparam logic [7:0] OVERLAY_RST = 8'd47;
  localparam logic [7:0] SYMBOL_RST  = 8'd62;

  // position limits and offset
  localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
  localparam logic signed [30:0] LAT_MIN = -31'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
  localparam logic signed [31:0] LON_MIN = -32'sd1800000000;
  localparam logic signed [31:0] POS_OFS = 32'sd900000000;

  // course code
  localparam logic [6:0] DIG_BASE = 7'd91;

  // reciprocal multipliers, exact for values below 2^31 (scaling)
  localparam int SC_S26  = 36;
  localparam int SC_S2K  = 43;
  localparam int SC_S15M = 55;
  localparam logic [31:0] SC_M26  = 32'(((64'd1 << SC_S26) + 64'd25) / 64'd26);
  localparam logic [31:0] SC_M2K  = 32'(((64'd1 << SC_S2K) + 64'd2709) / 64'd2710);
  localparam logic [31:0] SC_M15M = 32'(((64'd1 << SC_S15M) + 64'd15384614) / 64'd15384615);

  // reciprocal multipliers, exact for values below 2^27 (base-91 digits)
  localparam int DG_S1 = 34;
  localparam int DG_S2 = 41;
  localparam int DG_S3 = 47;
  localparam logic [31:0] DG_M1 = 32'(((64'd1 << DG_S1) + 64'd90) / 64'd91);
  localparam logic [31:0] DG_M2 = 32'(((64'd1 << DG_S2) + 64'd8280) / 64'd8281);
  localparam logic [31:0] DG_M3 = 32'(((64'd1 << DG_S3) + 64'd753570) / 64'd753571);

  // speed code thresholds, built at elaboration in q40 fixed point
  localparam int SPD_CODES  = 90;
  localparam int SPD_CODE_W = 7;

  function automatic logic [63:0] q40_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[103:40];
  endfunction

  localparam logic [63:0] Q40_ONE = 64'd1 << 40;
  localparam logic [63:0] EXP_X   = (Q40_ONE * 64'd7696) / 64'd100000;

  localparam logic [63:0] TAY_1  = q40_mul(Q40_ONE, EXP_X) / 64'd1;
  localparam logic [63:0] TAY_2  = q40_mul(TAY_1, EXP_X) / 64'd2;
  localparam logic [63:0] TAY_3  = q40_mul(TAY_2, EXP_X) / 64'd3;
  localparam logic [63:0] TAY_4  = q40_mul(TAY_3, EXP_X) / 64'd4;
  localparam logic [63:0] TAY_5  = q40_mul(TAY_4, EXP_X) / 64'd5;
  localparam logic [63:0] TAY_6  = q40_mul(TAY_5, EXP_X) / 64'd6;
  localparam logic [63:0] TAY_7  = q40_mul(TAY_6, EXP_X) / 64'd7;
  localparam logic [63:0] TAY_8  = q40_mul(TAY_7, EXP_X) / 64'd8;
  localparam logic [63:0] TAY_9  = q40_mul(TAY_8, EXP_X) / 64'd9;
  localparam logic [63:0] TAY_10 = q40_mul(TAY_9, EXP_X) / 64'd10;
  localparam logic [63:0] TAY_11 = q40_mul(TAY_10, EXP_X) / 64'd11;
  localparam logic [63:0] TAY_12 = q40_mul(TAY_11, EXP_X) / 64'd12;
  localparam logic [63:0] TAY_13 = q40_mul(TAY_12, EXP_X) / 64'd13;
  localparam logic [63:0] TAY_14 = q40_mul(TAY_13, EXP_X) / 64'd14;
  localparam logic [63:0] TAY_15 = q40_mul(TAY_14, EXP_X) / 64'd15;
  localparam logic [63:0] TAY_16 = q40_mul(TAY_15, EXP_X) / 64'd16;
  localparam logic [63:0] TAY_17 = q40_mul(TAY_16, EXP_X) / 64'd17;
  localparam logic [63:0] TAY_18 = q40_mul(TAY_17, EXP_X) / 64'd18;
  localparam logic [63:0] TAY_19 = q40_mul(TAY_18, EXP_X) / 64'd19;
  localparam logic [63:0] TAY_20 = q40_mul(TAY_19, EXP_X) / 64'd20;

  localparam logic [63:0] EXP_R = Q40_ONE + TAY_1 + TAY_2 + TAY_3 + TAY_4 + TAY_5
                                + TAY_6 + TAY_7 + TAY_8 + TAY_9 + TAY_10 + TAY_11
                                + TAY_12 + TAY_13 + TAY_14 + TAY_15 + TAY_16
                                + TAY_17 + TAY_18 + TAY_19 + TAY_20;

  typedef logic [SPD_CODES-1:0][15:0] spd_thr_t;

  // entry c holds the smallest speed_q4 that reaches code c+1
  function automatic spd_thr_t spd_thresholds();
    logic [63:0] e;
    spd_thr_t    thr;
    e = Q40_ONE;
    for (int c = 0; c < SPD_CODES; c++) begin
      e = q40_mul(e, EXP_R);
      thr[c] = 16'(((e + 64'h0000_000F_FFFF_FFFF) >> 36) - 64'd16);
    end
    return thr;
  endfunction

  localparam spd_thr_t SPD_THR = spd_thresholds();

  // stage payloads
  typedef struct packed {
    logic [30:0]          lat_pos;
    logic [30:0]          lon_pos;
    logic [7:0]           course_chr;
    logic [SPD_CODES-1:0] speed_therm;
  } front_t;

  typedef struct packed {
    logic [26:0] lat_sc;
    logic [26:0] lon_sc;
    logic [7:0]  course_chr;
    logic [7:0]  speed_chr;
  } scaled_t;

  // element 0 is the most significant digit, sent first
  typedef struct packed {
    logic [7:0]      speed_chr;
    logic [7:0]      course_chr;
    logic [3:0][7:0] lon_chr;
    logic [3:0][7:0] lat_chr;
  } frame_t;

endpackage

>>> design/compressed_position_encoder_core.sv
// Compressed position encoder: each accepted fix (latitude, longitude, course,
// speed) becomes the 14-byte compressed position field, sent one byte per
// transaction on the master stream with tlast on the final byte. Fixes pass
// a five-register pipeline (input conditioning, two scaling stages, two base-91
// digit stages) into a frame shift register; the first byte is valid once that
// register holds the fix. It sends one byte per cycle while m_tready is high and
// loads the next frame as the final byte leaves; the pipeline holds up to five
// more fixes while a frame drains. Overlay and symbol registers at byte addresses
// 0 and 4; the user must write them only while the stream is idle (not enforced).
module compressed_position_encoder_core import cpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [30:0] latitude_e7, [62:31] longitude_e7, [71:63] course_deg, [85:72] speed_q4
  input  logic [87:0]           s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] out_byte
  output logic [7:0]            m_tdata,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0] overlay_char;
  logic [7:0] symbol_char;
  logic [0:0] reg_idx;

  front_t  front_data;
  scaled_t scaled_data;
  frame_t  frame_data;
  logic    front_valid;
  logic    front_ready;
  logic    scaled_valid;
  logic    scaled_ready;
  logic    frame_valid;
  logic    frame_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_char <= OVERLAY_RST;
      symbol_char  <= SYMBOL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_OVERLAY: overlay_char <= pwdata[7:0];
        REG_SYMBOL:  symbol_char  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OVERLAY: prdata = {24'd0, overlay_char};
      REG_SYMBOL:  prdata = {24'd0, symbol_char};
      default:     prdata = '0;
    endcase
  end

  cpe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .latitude_e7  (s_tdata[30:0]),
    .longitude_e7 (s_tdata[62:31]),
    .course_deg   (s_tdata[71:63]),
    .speed_q4     (s_tdata[85:72]),
    .out_valid    (front_valid),
    .out_ready    (front_ready),
    .out_data     (front_data)
  );

  cpe_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (scaled_valid),
    .out_ready (scaled_ready),
    .out_data  (scaled_data)
  );

  cpe_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scaled_valid),
    .in_ready  (scaled_ready),
    .in_data   (scaled_data),
    .out_valid (frame_valid),
    .out_ready (frame_ready),
    .out_data  (frame_data)
  );

  cpe_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (frame_valid),
    .in_ready     (frame_ready),
    .in_data      (frame_data),
    .overlay_char (overlay_char),
    .symbol_char  (symbol_char),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (m_tdata),
    .out_last     (m_tlast)
  );

endmodule

>>> design/cpe_front.sv
// input stage: saturation, offset positions, course code and speed thermometer
module cpe_front import cpe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] latitude_e7,
  input  logic signed [31:0] longitude_e7,
  input  logic [8:0]         course_deg,
  input  logic [13:0]        speed_q4,
  output logic               out_valid,
  input  logic               out_ready,
  output front_t             out_data
);

  logic signed [30:0] lat_sat;
  logic signed [31:0] lon_sat;
  logic signed [31:0] lon_half;
  logic signed [31:0] lat_off;
  logic signed [31:0] lon_off;
  logic [6:0]         course_q;
  logic [6:0]         course_code;
  front_t             data_next;

  always_comb begin
    if (latitude_e7 > LAT_MAX) begin
      lat_sat = LAT_MAX;
    end else if (latitude_e7 < LAT_MIN) begin
      lat_sat = LAT_MIN;
    end else begin
      lat_sat = latitude_e7;
    end
    if (longitude_e7 > LON_MAX) begin
      lon_sat = LON_MAX;
    end else if (longitude_e7 < LON_MIN) begin
      lon_sat = LON_MIN;
    end else begin
      lon_sat = longitude_e7;
    end
    // floor division by two
    lon_half = lon_sat >>> 1;
    lat_off  = POS_OFS - {lat_sat[30], lat_sat};
    lon_off  = POS_OFS + lon_half;

    course_q    = course_deg[8:2];
    course_code = (course_q >= DIG_BASE) ? course_q - DIG_BASE : course_q;

    data_next.lat_pos    = lat_off[30:0];
    data_next.lon_pos    = lon_off[30:0];
    data_next.course_chr = {1'b0, course_code} + CHR_OFS;
    for (int c = 0; c < SPD_CODES; c++) begin
      data_next.speed_therm[c] = ({2'b00, speed_q4} >= SPD_THR[c]);
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

>>> design/cpe_scale.sv
// two stages: reciprocal quotients, then v/26 - v/2710 + v/15384615
module cpe_scale import cpe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  front_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output scaled_t out_data
);

  typedef struct packed {
    logic [26:0] q26;
    logic [19:0] q2k;
    logic [6:0]  q15m;
  } quot_t;

  function automatic quot_t scale_quot(input logic [30:0] v);
    logic [62:0] p26;
    logic [62:0] p2k;
    logic [62:0] p15m;
    quot_t       q;
    p26    = 63'(v) * 63'(SC_M26);
    p2k    = 63'(v) * 63'(SC_M2K);
    p15m   = 63'(v) * 63'(SC_M15M);
    q.q26  = 27'(p26 >> SC_S26);
    q.q2k  = 20'(p2k >> SC_S2K);
    q.q15m = 7'(p15m >> SC_S15M);
    return q;
  endfunction

  // monotone thermometer, so the code is the position of its top edge
  function automatic logic [7:0] speed_chr(input logic [SPD_CODES-1:0] therm);
    logic [SPD_CODES:0]    ext;
    logic [SPD_CODE_W-1:0] code;
    ext  = {1'b0, therm};
    code = '0;
    for (int c = 0; c < SPD_CODES; c++) begin
      if (ext[c] && !ext[c+1]) begin
        code = code | SPD_CODE_W'(c + 1);
      end
    end
    return {1'b0, code} + CHR_OFS;
  endfunction

  logic       a_valid;
  logic       a_ready;
  logic       in_ready_b;
  quot_t      a_lat;
  quot_t      a_lon;
  logic [7:0] a_course;
  logic [7:0] a_speed;

  assign in_ready_b = ~out_valid | out_ready;
  assign a_ready    = ~a_valid | in_ready_b;
  assign in_ready   = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_lat    <= scale_quot(in_data.lat_pos);
      a_lon    <= scale_quot(in_data.lon_pos);
      a_course <= in_data.course_chr;
      a_speed  <= speed_chr(in_data.speed_therm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready_b) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && in_ready_b) begin
      out_data.lat_sc     <= a_lat.q26 - 27'(a_lat.q2k) + 27'(a_lat.q15m);
      out_data.lon_sc     <= a_lon.q26 - 27'(a_lon.q2k) + 27'(a_lon.q15m);
      out_data.course_chr <= a_course;
      out_data.speed_chr  <= a_speed;
    end
  end

endmodule

>>> design/cpe_digits.sv
// two stages: base-91 quotients by reciprocal, then digit characters
module cpe_digits import cpe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  scaled_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output frame_t  out_data
);

  typedef struct packed {
    logic [26:0] v;
    logic [19:0] q1;
    logic [13:0] q2;
    logic [6:0]  q3;
  } dquot_t;

  function automatic dquot_t digit_quot(input logic [26:0] v);
    logic [58:0] p1;
    logic [58:0] p2;
    logic [58:0] p3;
    dquot_t      q;
    p1   = 59'(v) * 59'(DG_M1);
    p2   = 59'(v) * 59'(DG_M2);
    p3   = 59'(v) * 59'(DG_M3);
    q.v  = v;
    q.q1 = 20'(p1 >> DG_S1);
    q.q2 = 14'(p2 >> DG_S2);
    q.q3 = 7'(p3 >> DG_S3);
    return q;
  endfunction

  // remainders are below 91, so seven low bits carry them exactly
  function automatic logic [3:0][7:0] digit_chr(input dquot_t q);
    logic [6:0]      d1;
    logic [6:0]      d2;
    logic [6:0]      d3;
    logic [3:0][7:0] chr;
    d1 = q.q2[6:0] - q.q3 * DIG_BASE;
    d2 = q.q1[6:0] - q.q2[6:0] * DIG_BASE;
    d3 = q.v[6:0] - q.q1[6:0] * DIG_BASE;
    chr[0] = {1'b0, q.q3} + CHR_OFS;
    chr[1] = {1'b0, d1} + CHR_OFS;
    chr[2] = {1'b0, d2} + CHR_OFS;
    chr[3] = {1'b0, d3} + CHR_OFS;
    return chr;
  endfunction

  logic       a_valid;
  logic       a_ready;
  logic       b_ready;
  dquot_t     a_lat;
  dquot_t     a_lon;
  logic [7:0] a_course;
  logic [7:0] a_speed;

  assign b_ready  = ~out_valid | out_ready;
  assign a_ready  = ~a_valid | b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_lat    <= digit_quot(in_data.lat_sc);
      a_lon    <= digit_quot(in_data.lon_sc);
      a_course <= in_data.course_chr;
      a_speed  <= in_data.speed_chr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      out_data.lat_chr    <= digit_chr(a_lat);
      out_data.lon_chr    <= digit_chr(a_lon);
      out_data.course_chr <= a_course;
      out_data.speed_chr  <= a_speed;
    end
  end

endmodule

>>> design/cpe_serializer.sv
// frame shift register: loads fourteen bytes and sends one per transaction
module cpe_serializer import cpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  frame_t     in_data,
  input  logic [7:0] overlay_char,
  input  logic [7:0] symbol_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [FRAME_BYTES*8-1:0] frame;
  logic [CNT_W-1:0]         cnt;
  logic                     busy;
  logic                     xfer;
  logic                     load;

  assign out_valid = busy;
  assign out_byte  = frame[7:0];
  assign out_last  = (cnt == LAST_IDX);
  assign xfer      = busy & out_ready;
  // the next frame loads in the cycle the final byte leaves
  assign in_ready  = ~busy | (xfer & out_last);
  assign load      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (xfer) begin
      cnt <= cnt + 1'b1;
      if (out_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= {CHR_TAIL, in_data.speed_chr, in_data.course_chr, symbol_char,
                in_data.lon_chr, in_data.lat_chr, overlay_char, CHR_BANG};
    end else if (xfer) begin
      frame <= frame >> 8;
    end
  end

endmodule

>>> dv/tb.sv
// self-checking testbench for the compressed position encoder core
module tb;
  import cpe_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int FIELD_BYTES = 14;
  localparam int SPEED_STEPS = 90;
  localparam int RANDOM_PHASES = 4;
  localparam int FIXES_PER_PHASE = 70;
  localparam int DRAIN_CYCLES = 20;
  localparam longint LAT_LIM = 64'sd900000000;
  localparam longint LON_LIM = 64'sd1800000000;
  localparam logic [7:0] BYTE_BANG = 8'h21;
  localparam logic [7:0] BYTE_TAIL = 8'h47;
  localparam logic [7:0] DIGIT_OFS = 8'd33;

  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [8:0]         course;
    logic [13:0]        speed;
  } pos_fix_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } field_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [30:0] latitude_e7, [62:31] longitude_e7, [71:63] course_deg, [85:72] speed_q4
  logic [87:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [7:0] out_byte
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  field_byte_t field_bytes_q[$];
  field_byte_t want;
  logic [7:0]  overlay_cfg = OVERLAY_RST;
  logic [7:0]  symbol_cfg = SYMBOL_RST;
  logic [63:0] speed_step_q40 [1:SPEED_STEPS];
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  bit          sink_quiet = 1'b0;
  bit          source_quiet = 1'b0;

  compressed_position_encoder_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("compressed_position_encoder_core regression: fail");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] q40_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> 40);
  endfunction

  // powers of exp(0.07696) in q40, one per speed code
  task automatic build_speed_steps();
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] growth;
    logic [63:0] acc;
    x = ((64'd1 << 40) * 64'd7696) / 64'd100000;
    term = 64'd1 << 40;
    growth = 64'd1 << 40;
    for (int k = 1; k <= 20; k++) begin
      term = q40_product(term, x) / 64'(k);
      growth += term;
    end
    acc = 64'd1 << 40;
    for (int c = 1; c <= SPEED_STEPS; c++) begin
      acc = q40_product(acc, growth);
      speed_step_q40[c] = acc;
    end
  endtask

  function automatic logic [7:0] speed_code_of(input logic [13:0] q);
    logic [63:0] target;
    logic [7:0]  code;
    bit          done;
    target = (64'd16 + 64'(q)) << 36;
    code = 8'd0;
    done = 1'b0;
    for (int c = 1; c <= SPEED_STEPS; c++) begin
      if (!done) begin
        if (speed_step_q40[c] <= target) code = 8'(c);
        else done = 1'b1;
      end
    end
    return code;
  endfunction

  function automatic logic [31:0] scale_pos(input logic [31:0] v);
    return v / 32'd26 - v / 32'd2710 + v / 32'd15384615;
  endfunction

  task automatic push_field(input pos_fix_t f);
    longint      lat;
    longint      lon;
    logic [31:0] y;
    logic [31:0] x;
    logic [7:0]  b [FIELD_BYTES];
    field_byte_t fb;
    lat = longint'($signed(f.lat));
    lon = longint'($signed(f.lon));
    if (lat > LAT_LIM) lat = LAT_LIM;
    if (lat < -LAT_LIM) lat = -LAT_LIM;
    if (lon > LON_LIM) lon = LON_LIM;
    if (lon < -LON_LIM) lon = -LON_LIM;
    y = scale_pos(32'(LAT_LIM - lat));
    // floor of half the longitude
    x = scale_pos(32'(LAT_LIM + (lon >>> 1)));
    b[0] = BYTE_BANG;
    b[1] = overlay_cfg;
    for (int i = 3; i >= 0; i--) begin
      b[2 + i] = 8'(y % 91) + DIGIT_OFS;
      b[6 + i] = 8'(x % 91) + DIGIT_OFS;
      y = y / 91;
      x = x / 91;
    end
    b[10] = symbol_cfg;
    b[11] = 8'((32'(f.course) / 4) % 91) + DIGIT_OFS;
    b[12] = speed_code_of(f.speed) + DIGIT_OFS;
    b[13] = BYTE_TAIL;
    for (int i = 0; i < FIELD_BYTES; i++) begin
      fb.data = b[i];
      fb.last = (i == FIELD_BYTES - 1);
      field_bytes_q.push_back(fb);
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        if ($urandom_range(0, 63) == 0) sink_quiet = !sink_quiet;
        if (!sink_quiet && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (field_bytes_q.size() == 0) begin
        note_error($sformatf("unexpected byte %h last %b", m_tdata, m_tlast));
      end else begin
        want = field_bytes_q.pop_front();
        if (want.data !== m_tdata || want.last !== m_tlast)
          note_error($sformatf("byte mismatch: expected %h last %b, got %h last %b",
                               want.data, want.last, m_tdata, m_tlast));
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_fix(input pos_fix_t f);
    int gap;
    if ($urandom_range(0, 15) == 0) source_quiet = !source_quiet;
    gap = source_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, f.speed, f.course, f.lon, f.lat};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    push_field(f);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (field_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_OVERLAY) overlay_cfg = value;
    else symbol_cfg = value;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [0:0] idx);
    logic [7:0] value;
    value = (idx == REG_OVERLAY) ? overlay_cfg : symbol_cfg;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'd0, value})
      note_error($sformatf("register %0d readback: expected %h, got %h", idx,
                           {24'd0, value}, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_symbols(input logic [7:0] overlay, input logic [7:0] symbol);
    write_reg(REG_OVERLAY, overlay);
    write_reg(REG_SYMBOL, symbol);
    read_reg(REG_OVERLAY);
    read_reg(REG_SYMBOL);
  endtask

  function automatic pos_fix_t make_fix(input longint lat, input longint lon,
                                        input int course, input int speed);
    pos_fix_t f;
    f.lat = 31'(lat);
    f.lon = 32'(lon);
    f.course = 9'(course);
    f.speed = 14'(speed);
    return f;
  endfunction

  // mostly legal positions, some raw bit patterns that need clamping
  function automatic pos_fix_t random_fix();
    pos_fix_t f;
    if ($urandom_range(0, 4) != 0)
      f.lat = 31'(longint'($urandom_range(0, 1800000000)) - LAT_LIM);
    else
      f.lat = 31'($urandom);
    if ($urandom_range(0, 4) != 0)
      f.lon = 32'(longint'($urandom_range(0, 32'd3600000000)) - LON_LIM);
    else
      f.lon = 32'($urandom);
    f.course = ($urandom_range(0, 6) != 0) ? 9'($urandom_range(0, 359)) : 9'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: f.speed = 14'($urandom);
      5, 6, 7, 8:    f.speed = 14'($urandom_range(0, 480));
      default:       f.speed = 14'($urandom_range(0, 40));
    endcase
    return f;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_register_reset();
    read_reg(REG_OVERLAY);
    read_reg(REG_SYMBOL);
  endtask

  task automatic test_field_extremes();
    send_fix(make_fix(0, 0, 0, 0));
    send_fix(make_fix(LAT_LIM, LON_LIM, 359, 16383));
    send_fix(make_fix(-LAT_LIM, -LON_LIM, 4, 1));
    // raw field limits, clamped to the legal range
    send_fix(make_fix((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, 511, 15));
    send_fix(make_fix(-(64'sd1 << 30), -(64'sd1 << 31), 360, 16));
    send_fix(make_fix(LAT_LIM + 1, -LON_LIM - 1, 256, 16000));
    // odd negative longitudes round toward minus infinity
    send_fix(make_fix(1, -1, 3, 17));
    send_fix(make_fix(-1, -3, 364, 8191));
    send_fix(make_fix(LAT_LIM - 1, 1, 180, 100));
    send_fix(make_fix(-LAT_LIM + 1, LON_LIM - 1, 90, 1280));
    send_fix(make_fix(123456789, -987654321, 45, 337));
    send_fix(make_fix(-512345678, 1234567891, 508, 2));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_symbols(8'h00, 8'hff);
    repeat (3) send_fix(random_fix());
    wait_idle();
    set_symbols(8'hff, 8'h00);
    repeat (3) send_fix(random_fix());
    wait_idle();
  endtask

  task automatic test_random_fixes();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_symbols(8'($urandom), 8'($urandom));
      repeat (FIXES_PER_PHASE) send_fix(random_fix());
      wait_idle();
    end
  endtask

  initial begin
    build_speed_steps();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_field_extremes();
    test_register_extremes();
    test_random_fixes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("compressed_position_encoder_core regression: pass");
    else
      $display("compressed_position_encoder_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
design/cpe_pkg.sv
design/cpe_front.sv
design/cpe_scale.sv
design/cpe_digits.sv
design/cpe_serializer.sv
design/compressed_position_encoder_core.sv
dv/tb.sv
